/* sv/svq_pkg.sv */
// ============================================================================
// svq_pkg
// Shared types and codes of the split virtqueue ring engine.
// ============================================================================
`default_nettype none

package svq_pkg;

    typedef enum logic [1:0] {
        ACT_ADD  = 2'd0,
        ACT_DONE = 2'd1,
        ACT_POLL = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        OUT_DESC    = 3'd0,
        OUT_PUBLISH = 3'd1,
        OUT_ELEM    = 3'd2,
        OUT_EMPTY   = 3'd3,
        OUT_STORED  = 3'd4
    } t_outcome;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    localparam logic [1:0] FLAG_NEXT  = 2'b01;
    localparam logic [1:0] FLAG_WRITE = 2'b10;

    localparam logic [3:0] LOG2_MAX   = 4'd8;
    localparam logic [3:0] LOG2_RESET = 4'd8;

    typedef struct packed {
        t_outcome    outcome;
        logic [7:0]  slot;
        logic [63:0] out_addr;
        logic [31:0] out_len;
        logic [1:0]  desc_flags;
        logic [7:0]  next_slot;
        logic [7:0]  avail_slot;
        logic [7:0]  head_slot;
        logic [15:0] avail_total;
        logic [31:0] got_id;
        logic [31:0] got_len;
    } t_result;

endpackage

`default_nettype wire

/* sv/svq_ram.sv */
// ============================================================================
// svq_ram
// Generic one-write, one-read synchronous RAM with registered read data.
// ============================================================================
`default_nettype none

module svq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/split_virtqueue_ring_engine_core.sv */
// ============================================================================
// split_virtqueue_ring_engine_core
// Driver side of a split virtqueue: descriptor writes, available ring
// publishing, used ring completions and used ring polling.
// ============================================================================
// Usage:
// Items enter on the input channel (i_in_valid / o_in_stall) and each one
// except the unused action produces exactly one result item on the output
// channel (o_out_valid / i_out_stall). The ring size is set through the APB
// register at addresses 0 to 3; the user must write it only while the block
// is idle; the block does not enforce this. Add-buffer, device-complete and
// empty-poll items show their result in the cycle after acceptance. A poll
// that returns an element passes the read state, taking no item, as the used
// ring read is registered. Other items go at one per cycle unless stalled.
// The result sits in an output register. While the receiver stalls, that
// register holds and the block stalls its input once the register is full.
// Reset clears the ring indexes and the open-chain state and sets the size
// register to 256 slots. The used ring memory is not cleared; its entries are
// only read after they have been written.
// ============================================================================
`default_nettype none

module split_virtqueue_ring_engine_core
    import svq_pkg::*;
#(
    parameter int MAX_RING_SLOTS = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [63:0] i_buf_addr,
    input  wire logic [31:0] i_buf_len,
    input  wire logic        i_device_writable,
    input  wire logic        i_chain_last,
    input  wire logic [31:0] i_done_id,
    input  wire logic [31:0] i_done_len,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [2:0]  o_outcome,
    output logic      [7:0]  o_slot,
    output logic      [63:0] o_out_addr,
    output logic      [31:0] o_out_len,
    output logic      [1:0]  o_desc_flags,
    output logic      [7:0]  o_next_slot,
    output logic      [7:0]  o_avail_slot,
    output logic      [7:0]  o_head_slot,
    output logic      [15:0] o_avail_total,
    output logic      [31:0] o_got_id,
    output logic      [31:0] o_got_len
);

    localparam int         CAP    = (MAX_RING_SLOTS < 256) ? MAX_RING_SLOTS : 256;
    localparam int         AW     = $clog2(CAP);
    localparam logic [8:0] CAP_SZ = 9'(CAP);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state      r_state, n_state;
    logic [3:0]  r_ring_size_log2;
    logic [7:0]  r_free_slot;
    logic [7:0]  r_chain_start;
    logic        r_chain_open;
    logic [15:0] r_avail_index;
    logic [15:0] r_used_index;
    logic [7:0]  r_read_ptr;
    logic        r_out_valid;
    t_result     r_res, n_res;

    // ------------------------------------------------------------------
    // Ring size mask
    // ------------------------------------------------------------------
    logic [3:0] ring_lg;
    logic [8:0] ring_size;
    logic [7:0] ring_mask;

    always_comb begin
        ring_lg   = (r_ring_size_log2 > LOG2_MAX) ? LOG2_MAX : r_ring_size_log2;
        ring_size = 9'd1 << ring_lg;
        if (ring_size > CAP_SZ) begin
            ring_size = CAP_SZ;
        end
        ring_mask = 8'(ring_size - 9'd1);
    end

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    t_action act;
    logic    in_accept;
    logic    out_take;
    logic    cfg_write;

    assign act        = t_action'(i_action);
    assign out_take   = r_out_valid & ~i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) | (r_out_valid & i_out_stall);
    assign in_accept  = i_in_valid & ~o_in_stall;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready & ~paddr[2];
    assign prdata    = paddr[2] ? 32'd0 : {28'd0, r_ring_size_log2};

    // ------------------------------------------------------------------
    // Ring positions
    // ------------------------------------------------------------------
    logic [7:0]  cur_slot;
    logic [7:0]  nxt_slot;
    logic [7:0]  chain_head;
    logic [7:0]  avail_pos;
    logic [15:0] avail_next;
    logic [7:0]  used_pos;
    logic [7:0]  tail_pos;
    logic [7:0]  tail_next;
    logic        ring_empty;

    always_comb begin
        cur_slot   = r_free_slot & ring_mask;
        nxt_slot   = (cur_slot + 8'd1) & ring_mask;
        chain_head = r_chain_open ? r_chain_start : cur_slot;
        avail_pos  = r_avail_index[7:0] & ring_mask;
        avail_next = r_avail_index + 16'd1;
        used_pos   = r_used_index[7:0] & ring_mask;
        tail_pos   = r_read_ptr & ring_mask;
        tail_next  = (tail_pos + 8'd1) & ring_mask;
        ring_empty = (tail_pos == used_pos);
    end

    // ------------------------------------------------------------------
    // Used ring memory: id in the low half, length in the high half.
    // ------------------------------------------------------------------
    logic          mem_we;
    logic          mem_re;
    logic [63:0]   mem_rdata;
    logic          read_issue;
    logic          load_out;

    svq_ram #(
        .WIDTH (64),
        .DEPTH (CAP)
    ) u_used_ring (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (used_pos[AW-1:0]),
        .i_wdata ({i_done_len, i_done_id}),
        .i_re    (mem_re),
        .i_raddr (tail_pos[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (read_issue) begin
                    n_state = S_READ;
                end
            end
            S_READ:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Control outputs
    // ------------------------------------------------------------------
    always_comb begin
        read_issue = in_accept & (act == ACT_POLL) & ~ring_empty;
        mem_we     = in_accept & (act == ACT_DONE);
        mem_re     = read_issue;
        load_out   = 1'b0;
        case (r_state)
            S_IDLE:  load_out = in_accept & (act != ACT_NONE) & ~read_issue;
            S_READ:  load_out = 1'b1;
            default: load_out = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Result
    // ------------------------------------------------------------------
    always_comb begin
        n_res = '0;
        if (r_state == S_READ) begin
            n_res.outcome = OUT_ELEM;
            n_res.got_id  = mem_rdata[31:0];
            n_res.got_len = mem_rdata[63:32];
        end else begin
            case (act)
                ACT_ADD: begin
                    n_res.slot       = cur_slot;
                    n_res.out_addr   = i_buf_addr;
                    n_res.out_len    = i_buf_len;
                    n_res.desc_flags = i_device_writable ? FLAG_WRITE : 2'b00;
                    if (i_chain_last) begin
                        n_res.outcome     = OUT_PUBLISH;
                        n_res.avail_slot  = avail_pos;
                        n_res.head_slot   = chain_head;
                        n_res.avail_total = avail_next;
                    end else begin
                        n_res.outcome    = OUT_DESC;
                        n_res.desc_flags = n_res.desc_flags | FLAG_NEXT;
                        n_res.next_slot  = nxt_slot;
                    end
                end
                ACT_DONE: n_res.outcome = OUT_STORED;
                ACT_POLL: n_res.outcome = OUT_EMPTY;
                default:  n_res.outcome = OUT_EMPTY;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // State update
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_ring_size_log2 <= LOG2_RESET;
            r_free_slot      <= 8'd0;
            r_chain_start    <= 8'd0;
            r_chain_open     <= 1'b0;
            r_avail_index    <= 16'd0;
            r_used_index     <= 16'd0;
            r_read_ptr       <= 8'd0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_write) begin
                r_ring_size_log2 <= pwdata[3:0];
            end
            if (in_accept) begin
                case (act)
                    ACT_ADD: begin
                        r_free_slot   <= nxt_slot;
                        r_chain_start <= chain_head;
                        r_chain_open  <= ~i_chain_last;
                        if (i_chain_last) begin
                            r_avail_index <= avail_next;
                        end
                    end
                    ACT_DONE: r_used_index <= r_used_index + 16'd1;
                    ACT_POLL: begin
                        if (!ring_empty) begin
                            r_read_ptr <= tail_next;
                        end
                    end
                    default: ;
                endcase
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_outcome     = r_res.outcome;
    assign o_slot        = r_res.slot;
    assign o_out_addr    = r_res.out_addr;
    assign o_out_len     = r_res.out_len;
    assign o_desc_flags  = r_res.desc_flags;
    assign o_next_slot   = r_res.next_slot;
    assign o_avail_slot  = r_res.avail_slot;
    assign o_head_slot   = r_res.head_slot;
    assign o_avail_total = r_res.avail_total;
    assign o_got_id      = r_res.got_id;
    assign o_got_len     = r_res.got_len;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The output register must be free while a used ring read is in flight.
    a_read_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> !r_out_valid)
        else $error("output register busy during used ring read");

    // A poll of a non-empty ring always goes through the read cycle.
    a_poll_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        read_issue |=> r_state == S_READ)
        else $error("poll did not enter the read cycle");

    // The read cycle ends with the element in the output register.
    a_read_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |=> r_state == S_IDLE && r_out_valid && o_outcome == OUT_ELEM)
        else $error("used ring read did not deliver an element");

    // Memory write and read never share a cycle.
    a_mem_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("used ring written and read in the same cycle");

endmodule

`default_nettype wire
